### design/assert_macros.svh
// Shared assertion macros; each use is clocked on i_clk and idle in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ITP_ASSERT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ITP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### design/itp_pkg.sv
package itp_pkg;

    localparam int CHAR_W = 8;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [1:0]        t_prec;

    localparam t_char CH_PLUS   = 8'h2B;
    localparam t_char CH_MINUS  = 8'h2D;
    localparam t_char CH_STAR   = 8'h2A;
    localparam t_char CH_SLASH  = 8'h2F;
    localparam t_char CH_LPAREN = 8'h28;
    localparam t_char CH_RPAREN = 8'h29;

    // Letters and digits pass straight to the output
    function automatic logic itp_is_alnum(input t_char c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic t_prec itp_prec(input t_char c);
        t_prec p;
        p = 2'd0;
        if ((c == CH_PLUS) || (c == CH_MINUS)) begin
            p = 2'd1;
        end else if ((c == CH_STAR) || (c == CH_SLASH)) begin
            p = 2'd2;
        end
        return p;
    endfunction

    // Swap brackets for the reversed walk
    function automatic t_char itp_swap(input t_char c);
        t_char r;
        r = c;
        if (c == CH_LPAREN) begin
            r = CH_RPAREN;
        end else if (c == CH_RPAREN) begin
            r = CH_LPAREN;
        end
        return r;
    endfunction

endpackage

### design/itp_channels.sv
interface itp_in_if;
    import itp_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_in;
    logic              end_of_expr;

    modport source (output valid, output char_in, output end_of_expr, input ready);
    modport sink   (input valid, input char_in, input end_of_expr, output ready);
endinterface

interface itp_out_if;
    import itp_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_out;
    logic              last_out;
    logic              overflow;

    modport source (output valid, output char_out, output last_out, output overflow,
                    input ready);
    modport sink   (input valid, input char_out, input last_out, input overflow,
                    output ready);
endinterface

### design/itp_ram.sv
module itp_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry with a registered result
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/infix_to_prefix_converter.sv
// Load: one input transaction per cycle; an item without the end mark finishes at once.
// Conversion after the end mark: fetch, decode and process per stored character; a pop-wait
// per popped or flushed stack entry or dropped matching bracket; read-modify-write of memories.
// Readout per prefix character: memory read, output register, handshake.
// Reset (synchronous, active low) clears counters, flags and handshake; memory
// contents stay undefined and are never used before being written.
`include "assert_macros.svh"

module infix_to_prefix_converter #(
    parameter int MAX_LEN = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    itp_in_if.sink   i_in,
    itp_out_if.source o_out
);
    import itp_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam logic [CW-1:0] LEN_C = CW'(MAX_LEN);
    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [CW-1:0] TWO_C = CW'(2);

    typedef enum logic [3:0] {
        S_LOAD,
        S_FETCH,
        S_DECODE,
        S_PROC,
        S_POPWAIT,
        S_FLUSH,
        S_OUT_FETCH,
        S_OUT_LOAD,
        S_OUT_HOLD
    } t_state;

    t_state        r_state, n_state;
    t_state        r_ret, n_ret;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_sp, n_sp;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_optr, n_optr;
    logic          r_ovf, n_ovf;
    t_char         r_cur, n_cur;
    t_char         r_tos, n_tos;
    t_char         r_out_char, n_out_char;
    logic          r_out_last, n_out_last;
    logic          r_out_valid, n_out_valid;

    logic          ib_we, st_we, ob_we;
    logic [AW-1:0] ib_waddr, st_waddr, ob_waddr;
    t_char         ib_wdata, st_wdata, ob_wdata;
    logic [AW-1:0] ib_raddr, st_raddr, ob_raddr;
    t_char         ib_rdata, st_rdata, ob_rdata;

    logic [CW-1:0] idx_m1, sp_m2, optr_m1;
    logic          in_acc, has_top, top_open, can_emit, can_push;

    // Memories: input characters, operator stack, prefix result
    itp_ram #(.DEPTH(MAX_LEN), .WIDTH(CHAR_W)) u_ibuf (
        .i_clk(i_clk), .i_we(ib_we), .i_waddr(ib_waddr), .i_wdata(ib_wdata),
        .i_raddr(ib_raddr), .o_rdata(ib_rdata)
    );
    itp_ram #(.DEPTH(MAX_LEN), .WIDTH(CHAR_W)) u_stack (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_waddr), .i_wdata(st_wdata),
        .i_raddr(st_raddr), .o_rdata(st_rdata)
    );
    itp_ram #(.DEPTH(MAX_LEN), .WIDTH(CHAR_W)) u_obuf (
        .i_clk(i_clk), .i_we(ob_we), .i_waddr(ob_waddr), .i_wdata(ob_wdata),
        .i_raddr(ob_raddr), .o_rdata(ob_rdata)
    );

    // Fixed read addresses: next input character, entry under the top, next result
    assign idx_m1   = r_idx - ONE_C;
    assign sp_m2    = r_sp - TWO_C;
    assign optr_m1  = r_optr - ONE_C;
    assign ib_raddr = idx_m1[AW-1:0];
    assign st_raddr = sp_m2[AW-1:0];
    assign ob_raddr = optr_m1[AW-1:0];

    assign in_acc   = i_in.valid && i_in.ready;
    assign has_top  = (r_sp != '0);
    assign top_open = (r_tos == CH_LPAREN);
    assign can_emit = (r_n < LEN_C);
    assign can_push = (r_sp < LEN_C);

    assign i_in.ready     = (r_state == S_LOAD);
    assign o_out.valid    = r_out_valid;
    assign o_out.char_out = r_out_char;
    assign o_out.last_out = r_out_last;
    assign o_out.overflow = r_ovf;

    // Next-state and memory control
    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_sp        = r_sp;
        n_n         = r_n;
        n_optr      = r_optr;
        n_ovf       = r_ovf;
        n_cur       = r_cur;
        n_tos       = r_tos;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid;
        ib_we       = 1'b0;
        ib_waddr    = r_cnt[AW-1:0];
        ib_wdata    = i_in.char_in;
        st_we       = 1'b0;
        st_waddr    = r_sp[AW-1:0];
        st_wdata    = r_cur;
        ob_we       = 1'b0;
        ob_waddr    = r_n[AW-1:0];
        ob_wdata    = r_tos;

        unique case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    // Store or drop the character
                    if (r_cnt < LEN_C) begin
                        ib_we = 1'b1;
                        n_cnt = r_cnt + ONE_C;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.end_of_expr) begin
                        n_idx   = (r_cnt < LEN_C) ? r_cnt + ONE_C : r_cnt;
                        n_sp    = '0;
                        n_n     = '0;
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                n_state = S_DECODE;
            end
            S_DECODE: begin
                n_cur   = itp_swap(ib_rdata);
                n_state = S_PROC;
            end
            S_PROC: begin
                priority if (itp_is_alnum(r_cur)) begin
                    // Operand goes straight out
                    ob_wdata = r_cur;
                    ob_we    = can_emit;
                    n_n      = can_emit ? r_n + ONE_C : r_n;
                    n_idx    = idx_m1;
                    n_state  = (r_idx == ONE_C) ? S_FLUSH : S_FETCH;
                end else if (r_cur == CH_LPAREN) begin
                    st_we   = can_push;
                    n_sp    = can_push ? r_sp + ONE_C : r_sp;
                    n_tos   = can_push ? r_cur : r_tos;
                    n_idx   = idx_m1;
                    n_state = (r_idx == ONE_C) ? S_FLUSH : S_FETCH;
                end else if (r_cur == CH_RPAREN) begin
                    if (has_top && !top_open) begin
                        // Pop an operator to the output and retry
                        ob_we   = can_emit;
                        n_n     = can_emit ? r_n + ONE_C : r_n;
                        n_sp    = r_sp - ONE_C;
                        n_ret   = S_PROC;
                        n_state = S_POPWAIT;
                    end else if (has_top) begin
                        // Drop the matching bracket
                        n_sp    = r_sp - ONE_C;
                        n_idx   = idx_m1;
                        n_ret   = (r_idx == ONE_C) ? S_FLUSH : S_FETCH;
                        n_state = S_POPWAIT;
                    end else begin
                        // Unmatched bracket: drop it
                        n_idx   = idx_m1;
                        n_state = (r_idx == ONE_C) ? S_FLUSH : S_FETCH;
                    end
                end else begin
                    if (has_top && !top_open && (itp_prec(r_cur) < itp_prec(r_tos))) begin
                        ob_we   = can_emit;
                        n_n     = can_emit ? r_n + ONE_C : r_n;
                        n_sp    = r_sp - ONE_C;
                        n_ret   = S_PROC;
                        n_state = S_POPWAIT;
                    end else begin
                        st_we   = can_push;
                        n_sp    = can_push ? r_sp + ONE_C : r_sp;
                        n_tos   = can_push ? r_cur : r_tos;
                        n_idx   = idx_m1;
                        n_state = (r_idx == ONE_C) ? S_FLUSH : S_FETCH;
                    end
                end
            end
            S_POPWAIT: begin
                // Reload the cached top from the stack memory
                n_tos   = st_rdata;
                n_state = r_ret;
            end
            S_FLUSH: begin
                if (has_top) begin
                    ob_we   = can_emit && !top_open;
                    n_n     = (can_emit && !top_open) ? r_n + ONE_C : r_n;
                    n_sp    = r_sp - ONE_C;
                    n_ret   = S_FLUSH;
                    n_state = S_POPWAIT;
                end else if (r_n == '0) begin
                    n_cnt   = '0;
                    n_ovf   = 1'b0;
                    n_state = S_LOAD;
                end else begin
                    n_optr  = r_n;
                    n_state = S_OUT_FETCH;
                end
            end
            S_OUT_FETCH: begin
                n_state = S_OUT_LOAD;
            end
            S_OUT_LOAD: begin
                n_out_char  = ob_rdata;
                n_out_last  = (r_optr == ONE_C);
                n_out_valid = 1'b1;
                n_optr      = optr_m1;
                n_state     = S_OUT_HOLD;
            end
            S_OUT_HOLD: begin
                if (o_out.ready) begin
                    n_out_valid = 1'b0;
                    if (r_optr == '0) begin
                        n_cnt   = '0;
                        n_sp    = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_OUT_FETCH;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_ret       <= S_LOAD;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_sp        <= '0;
            r_n         <= '0;
            r_optr      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_sp        <= n_sp;
            r_n         <= n_n;
            r_optr      <= n_optr;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
        r_cur      <= n_cur;
        r_tos      <= n_tos;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    `ITP_ASSERT(a_no_load_while_out, i_in.ready, !o_out.valid, "input taken during readout")
    `ITP_ASSERT(a_emit_bounded, 1'b1, (r_n <= LEN_C) && (r_sp <= LEN_C), "counter past capacity")
    `ITP_ASSERT(a_last_is_final, o_out.valid && o_out.last_out, r_optr == '0, "last before end")
    `ITP_ASSERT_NEXT(a_back_to_load, o_out.valid && o_out.ready && o_out.last_out,
                     i_in.ready && (r_cnt == '0) && !r_ovf, "no return to load after last")

endmodule

### tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import itp_pkg::*;

    localparam int BUF_DEPTH    = 64;
    localparam int RANDOM_ITEMS = 330;
    localparam int SETTLE_LIMIT = 1200;

    typedef struct packed {
        t_char ch;
        logic  last;
        logic  ovf;
    } t_prefix_char;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_MOSTLY,
        RDY_COMB
    } t_ready_mode;

    // Tracks stored characters, predicts the prefix string, checks the output stream
    class prefix_checker;
        t_char        stored[$];
        bit           dropped;
        t_prefix_char prefix_due[$];
        int unsigned  mismatches;

        function bit is_operand(t_char c);
            return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
        endfunction

        function int unsigned rank(t_char c);
            case (c)
                CH_PLUS, CH_MINUS: return 1;
                CH_STAR, CH_SLASH: return 2;
                default:           return 0;
            endcase
        endfunction

        // Walk the stored expression backward with brackets mirrored
        function void convert_stored();
            t_char        stk[$];
            t_char        rev[$];
            t_char        c;
            t_prefix_char item;
            for (int i = stored.size() - 1; i >= 0; i--) begin
                c = stored[i];
                if (c == CH_LPAREN) begin
                    c = CH_RPAREN;
                end else if (c == CH_RPAREN) begin
                    c = CH_LPAREN;
                end
                if (is_operand(c)) begin
                    rev.push_back(c);
                end else if (c == CH_LPAREN) begin
                    stk.push_back(c);
                end else if (c == CH_RPAREN) begin
                    // unmatched closing bracket empties the stack and vanishes
                    while (stk.size() > 0 && stk[$] != CH_LPAREN) begin
                        rev.push_back(stk.pop_back());
                    end
                    if (stk.size() > 0) begin
                        void'(stk.pop_back());
                    end
                end else begin
                    while (stk.size() > 0 && stk[$] != CH_LPAREN &&
                           rank(c) < rank(stk[$])) begin
                        rev.push_back(stk.pop_back());
                    end
                    stk.push_back(c);
                end
            end
            // flush, dropping any opening bracket left behind
            while (stk.size() > 0) begin
                c = stk.pop_back();
                if (c != CH_LPAREN) begin
                    rev.push_back(c);
                end
            end
            for (int k = rev.size() - 1; k >= 0; k--) begin
                item.ch   = rev[k];
                item.last = (k == 0);
                item.ovf  = dropped;
                prefix_due.push_back(item);
            end
            stored  = {};
            dropped = 1'b0;
        endfunction

        function void note_char(t_char c, bit eoe);
            if (stored.size() < BUF_DEPTH) begin
                stored.push_back(c);
            end else begin
                dropped = 1'b1;
            end
            if (eoe) begin
                convert_stored();
            end
        endfunction

        function int unsigned pending();
            return prefix_due.size();
        endfunction

        task report_mismatch(string msg);
            $display("%0t ns: mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_char(t_char c, logic l, logic o);
            t_prefix_char want;
            if (prefix_due.size() == 0) begin
                report_mismatch($sformatf("unexpected char %h last %b ovf %b", c, l, o));
            end else begin
                want = prefix_due.pop_front();
                if (c !== want.ch || l !== want.last || o !== want.ovf) begin
                    report_mismatch($sformatf("got char %h last %b ovf %b, want %h %b %b",
                        c, l, o, want.ch, want.last, want.ovf));
                end
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    itp_in_if  in_ch ();
    itp_out_if out_ch ();

    infix_to_prefix_converter #(
        .MAX_LEN (BUF_DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    prefix_checker chk = new();

    int unsigned burst_left;
    int unsigned items_sent;
    t_ready_mode rdy_mode;
    int unsigned rdy_left;
    int unsigned rdy_tick;

    // Free-running clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Hard stop
    initial begin
        #5_000_000;
        $display("tb NOT OK");
        $finish;
    end

    // Receiver stalls: switch between stall patterns in random stretches
    initial begin
        out_ch.ready = 1'b0;
        rdy_left     = 0;
        rdy_tick     = 0;
        rdy_mode     = RDY_ALWAYS;
        forever begin
            @(negedge i_clk);
            if (rdy_left == 0) begin
                rdy_mode = t_ready_mode'($urandom_range(0, 3));
                rdy_left = $urandom_range(20, 200);
            end
            rdy_left--;
            rdy_tick++;
            case (rdy_mode)
                RDY_ALWAYS: out_ch.ready = 1'b1;
                RDY_COIN:   out_ch.ready = 1'($urandom_range(0, 1));
                RDY_MOSTLY: out_ch.ready = ($urandom_range(0, 3) != 0);
                RDY_COMB:   out_ch.ready = ((rdy_tick % 7) < 3);
                default:    out_ch.ready = 1'b1;
            endcase
        end
    end

    // Check every accepted output transaction
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            chk.check_char(out_ch.char_out, out_ch.last_out, out_ch.overflow);
        end
    end

    // Drive one character, idling between bursts, and hold until accepted
    task send_char(t_char c, bit eoe);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            repeat (gap) begin
                @(negedge i_clk);
                in_ch.valid = 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        in_ch.valid       = 1'b1;
        in_ch.char_in     = c;
        in_ch.end_of_expr = eoe;
        do @(posedge i_clk); while (!in_ch.ready);
        chk.note_char(c, eoe);
        items_sent++;
    endtask

    task send_expr(t_char chars[$]);
        foreach (chars[i]) begin
            send_char(chars[i], i == chars.size() - 1);
        end
    endtask

    // Hold the input until every predicted character has come out
    task drain();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (chk.pending() != 0) @(posedge i_clk);
        burst_left = 0;
    endtask

    function automatic void text_to_chars(string s, output t_char q[$]);
        q = {};
        for (int i = 0; i < s.len(); i++) begin
            q.push_back(t_char'(s[i]));
        end
    endfunction

    function automatic t_char rand_operand();
        case ($urandom_range(0, 2))
            0:       return t_char'(8'h30 + $urandom_range(0, 9));
            1:       return t_char'(8'h41 + $urandom_range(0, 25));
            default: return t_char'(8'h61 + $urandom_range(0, 25));
        endcase
    endfunction

    function automatic t_char rand_operator();
        case ($urandom_range(0, 3))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    // Mostly well-formed expressions, some jumbled, some raw bytes
    function automatic void build_expr(int unsigned len, output t_char q[$]);
        int unsigned kind;
        int unsigned depth;
        int unsigned room;
        bit          want_operand;
        string       mix;
        kind         = $urandom_range(0, 9);
        depth        = 0;
        want_operand = 1'b1;
        mix          = "aZ09+-*/()";
        q = {};
        while (q.size() < len) begin
            room = len - q.size();
            if (kind == 9) begin
                q.push_back(t_char'($urandom_range(0, 255)));
            end else if (kind >= 7) begin
                if ($urandom_range(0, 7) == 0) begin
                    q.push_back(t_char'($urandom_range(0, 255)));
                end else begin
                    q.push_back(t_char'(mix[$urandom_range(0, mix.len() - 1)]));
                end
            end else if (want_operand) begin
                if (room > depth + 3 && $urandom_range(0, 3) == 0) begin
                    q.push_back(CH_LPAREN);
                    depth++;
                end else begin
                    q.push_back(rand_operand());
                    want_operand = 1'b0;
                end
            end else if (depth > 0 && (room <= depth || $urandom_range(0, 2) == 0)) begin
                q.push_back(CH_RPAREN);
                depth--;
            end else begin
                q.push_back(rand_operator());
                want_operand = 1'b1;
            end
        end
    endfunction

    // Main sequence
    initial begin
        t_char       expr[$];
        int unsigned expr_no;
        int unsigned len;
        in_ch.valid       = 1'b0;
        in_ch.char_in     = '0;
        in_ch.end_of_expr = 1'b0;
        i_rst_n           = 1'b0;
        burst_left        = 0;
        items_sent        = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: all operators, brackets, lone and unmatched brackets, byte extremes
        text_to_chars("9-b/c*A+e", expr);
        send_expr(expr);
        text_to_chars("(a+b)*c", expr);
        send_expr(expr);
        text_to_chars("x", expr);
        send_expr(expr);
        text_to_chars("(", expr);
        send_expr(expr);
        text_to_chars(")", expr);
        send_expr(expr);
        text_to_chars("a)b", expr);
        send_expr(expr);
        expr = {8'h5A, 8'h00, 8'h30, 8'hFF, 8'h7A};
        send_expr(expr);
        drain();

        // Random expressions; a few fill or overrun the buffer
        expr_no = 0;
        while (items_sent < RANDOM_ITEMS) begin
            case (expr_no)
                2:       len = BUF_DEPTH + 1;
                6:       len = BUF_DEPTH;
                12:      len = BUF_DEPTH + 6;
                default: len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 72)
                                                             : $urandom_range(1, 12);
            endcase
            build_expr(len, expr);
            send_expr(expr);
            expr_no++;
            if (expr_no == 15) begin
                drain();
            end
        end

        // Let the tail drain, then give stray output a chance to show
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (chk.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_LIMIT) @(posedge i_clk);

        if (chk.mismatches == 0 && chk.pending() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
